[rtl/sid_pkg.sv]
// ----------------------------------------------------------------------------
// sid_pkg
// Shared constants for the 2D segment intersection block.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int SID_COORD_WIDTH = 16;
  localparam int SID_FRAC_BITS   = 8;
  localparam int SID_QUEUE_DEPTH = 4;

  localparam int              TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

endpackage

[rtl/segment_intersection_2d.sv]
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Tests two 2D segments for a crossing, touching included, and returns the crossing point.
//
//   channel   dir  contents (low bits first)
//   s_axis    in   tdata: a_start_x a_start_z a_end_x a_end_z
//                         b_start_x b_start_z b_end_x b_end_z
//   m_axis    out  tdata: cross_x cross_z, tuser: hit
//   cfg       in   cfg_we / cfg_wdata: tolerance
//
// One request per cycle sustained while m_axis_tready stays high; each passes
// through the classify pipeline, the queue and the divide pipeline, one
// quotient bit per stage. A queue of QUEUE_DEPTH entries lets the two pipelines
// stall apart; m_axis_tready low stalls only the divide side until the queue
// fills. Reset clears all valid state and sets tolerance to 1.
// ----------------------------------------------------------------------------
module segment_intersection_2d import sid_pkg::*; #(
  parameter int COORD_WIDTH = SID_COORD_WIDTH,
  parameter int FRAC_BITS   = SID_FRAC_BITS,
  parameter int QUEUE_DEPTH = SID_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_start_x, a_start_z, a_end_x, a_end_z, b_start_x, b_start_z, b_end_x, b_end_z
  input  logic [8*COORD_WIDTH-1:0]            s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cross_x, cross_z, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  // hit
  output logic                                m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [TOL_WIDTH-1:0]                cfg_wdata
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int CW  = 2 * DW + 1;
  localparam int IW  = 1 + 2*COORD_WIDTH + 2*DW + 2*CW;
  localparam int OTW = ((2*COORD_WIDTH+7)/8)*8;

  logic [TOL_WIDTH-1:0] tolerance;
  logic                 f_valid, f_ready, q_valid, q_ready;
  logic [IW-1:0]        f_item, q_item;
  logic signed [COORD_WIDTH-1:0] cx, cz;

  always_ff @(posedge clk) begin
    if (rst) tolerance <= TOL_RESET;
    else if (cfg_we) tolerance <= cfg_wdata;
  end

  sid_front #(.W(COORD_WIDTH), .F(FRAC_BITS), .IW(IW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .tolerance (tolerance),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  sid_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  sid_back #(.W(COORD_WIDTH), .IW(IW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_hit   (m_axis_tuser),
    .out_x     (cx),
    .out_z     (cz)
  );

  assign m_axis_tdata = OTW'({cz, cx});

endmodule

[rtl/sid_front.sv]
// ----------------------------------------------------------------------------
// sid_front
// Front pipeline: cross products, tolerance tests and hit classification.
// ----------------------------------------------------------------------------
module sid_front import sid_pkg::*; #(
  parameter int W = SID_COORD_WIDTH,
  parameter int F = SID_FRAC_BITS,
  parameter int IW = 1 + 2*W + 2*(W+1) + 2*(2*(W+1)+1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [8*W-1:0]       in_data,
  input  logic [TOL_WIDTH-1:0] tolerance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IW-1:0]        out_item
);

  localparam int DW  = W + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int TQW = TOL_WIDTH + 2 * F;
  localparam int LW  = (CW > TQW) ? CW : TQW;

  logic en;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: captured coordinates u1x u1z u2x u2z v1x v1z v2x v2z
  logic signed [W-1:0] c1r [8];

  // stage 2
  logic signed [DW-1:0] ext [8];
  logic signed [DW-1:0] opa [20];
  logic signed [DW-1:0] opb [20];
  logic signed [PW-1:0] prod [20];
  logic signed [DW-1:0] d_u1u2x, d_u1u2z, d_v1v2x, d_v1v2z;
  logic signed [DW-1:0] d_u1v1x, d_u1v1z, d_u2v1x, d_u2v1z;
  logic signed [DW-1:0] d_u1v2x, d_u1v2z, d_u2v2x, d_u2v2z;
  logic signed [DW-1:0] d_v2v1x, d_v2v1z, dux_c, duz_c;
  logic signed [PW-1:0] pr2 [20];
  logic signed [W-1:0]  u1x2, u1z2;
  logic signed [DW-1:0] dux2, duz2;

  // stage 3: crosses den, num, c1, c2, e1, e2
  logic signed [CW-1:0] cr [6];
  logic                 dok [8];
  logic signed [PW-1:0] tolp;
  logic signed [CW-1:0] cr3 [6];
  logic                 dok3 [8];
  logic signed [W-1:0]  u1x3, u1z3;
  logic signed [DW-1:0] dux3, duz3;

  // stage 4
  logic [CW-1:0]  mag [6];
  logic [LW-1:0]  magx [4];
  logic           nzden4, zden4;
  logic           nzs4 [4];
  logic           zrs4 [4];
  logic           sgs4 [4];
  logic           big4 [4];
  logic [TQW-1:0] lo4 [4];
  logic           dok4 [8];
  logic signed [CW-1:0] den4, num4;
  logic signed [W-1:0]  u1x4, u1z4;
  logic signed [DW-1:0] dux4, duz4;

  // stage 5: [0] side test of a against b's line, [1] b against a's line
  logic [2*TQW-1:0] sp5 [2];
  logic             pre5 [2];
  logic             bg5 [2];
  logic             nzden5, zden5;
  logic             nzs5 [4];
  logic             dok5 [8];
  logic signed [CW-1:0] den5, num5;
  logic signed [W-1:0]  u1x5, u1z5;
  logic signed [DW-1:0] dux5, duz5;

  // stage 6
  logic [2*TQW-1:0] tq;
  logic             above [2];
  logic             near, on_any, meet, hit;

  assign en        = !v6 || out_ready;
  assign in_ready  = en;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) c1r[k] <= in_data[k*W +: W];
    end
  end

  // stage 2
  always_comb begin
    for (int k = 0; k < 8; k++) ext[k] = {c1r[k][W-1], c1r[k]};
    d_u1u2x = ext[0] - ext[2];
    d_u1u2z = ext[1] - ext[3];
    d_v1v2x = ext[4] - ext[6];
    d_v1v2z = ext[5] - ext[7];
    d_u1v1x = ext[0] - ext[4];
    d_u1v1z = ext[1] - ext[5];
    d_u2v1x = ext[2] - ext[4];
    d_u2v1z = ext[3] - ext[5];
    d_u1v2x = ext[0] - ext[6];
    d_u1v2z = ext[1] - ext[7];
    d_u2v2x = ext[2] - ext[6];
    d_u2v2z = ext[3] - ext[7];
    d_v2v1x = ext[6] - ext[4];
    d_v2v1z = ext[7] - ext[5];
    dux_c   = ext[2] - ext[0];
    duz_c   = ext[3] - ext[1];
    // den
    opa[0]  = d_u1u2x; opb[0]  = d_v1v2z;
    opa[1]  = d_u1u2z; opb[1]  = d_v1v2x;
    // num
    opa[2]  = d_u1v1x; opb[2]  = d_v1v2z;
    opa[3]  = d_u1v1z; opb[3]  = d_v1v2x;
    // c1: v1 against line of a
    opa[4]  = d_u1v1x; opb[4]  = d_u2v1z;
    opa[5]  = d_u2v1x; opb[5]  = d_u1v1z;
    // c2: v2 against line of a
    opa[6]  = d_u1v2x; opb[6]  = d_u2v2z;
    opa[7]  = d_u2v2x; opb[7]  = d_u1v2z;
    // e1: u1 against line of b
    opa[8]  = d_v2v1x; opb[8]  = d_u1v1z;
    opa[9]  = d_u1v1x; opb[9]  = d_v2v1z;
    // e2: u2 against line of b
    opa[10] = d_v2v1x; opb[10] = d_u2v1z;
    opa[11] = d_u2v1x; opb[11] = d_v2v1z;
    // endpoint box products for u1, u2, v1, v2 in x then z
    opa[12] = d_u1v1x; opb[12] = d_u1v2x;
    opa[13] = d_u1v1z; opb[13] = d_u1v2z;
    opa[14] = d_u2v1x; opb[14] = d_u2v2x;
    opa[15] = d_u2v1z; opb[15] = d_u2v2z;
    opa[16] = d_u1v1x; opb[16] = d_u2v1x;
    opa[17] = d_u1v1z; opb[17] = d_u2v1z;
    opa[18] = d_u1v2x; opb[18] = d_u2v2x;
    opa[19] = d_u1v2z; opb[19] = d_u2v2z;
    for (int k = 0; k < 20; k++) prod[k] = opa[k] * opb[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 20; k++) pr2[k] <= prod[k];
      u1x2 <= c1r[0];
      u1z2 <= c1r[1];
      dux2 <= dux_c;
      duz2 <= duz_c;
    end
  end

  // stage 3
  assign tolp = $signed(PW'(tolerance));

  always_comb begin
    for (int k = 0; k < 6; k++) cr[k] = CW'(pr2[2*k]) - CW'(pr2[2*k+1]);
    for (int j = 0; j < 8; j++) dok[j] = pr2[12+j] < tolp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) cr3[k] <= cr[k];
      for (int j = 0; j < 8; j++) dok3[j] <= dok[j];
      u1x3 <= u1x2;
      u1z3 <= u1z2;
      dux3 <= dux2;
      duz3 <= duz2;
    end
  end

  // stage 4
  always_comb begin
    for (int k = 0; k < 6; k++) mag[k] = cr3[k][CW-1] ? (~cr3[k] + 1'b1) : cr3[k];
    for (int k = 0; k < 4; k++) magx[k] = LW'(mag[k+2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nzden4 <= mag[0] < CW'(tolerance);
      zden4  <= cr3[0] == '0;
      for (int k = 0; k < 4; k++) begin
        nzs4[k] <= mag[k+2] < CW'(tolerance);
        zrs4[k] <= cr3[k+2] == '0;
        sgs4[k] <= cr3[k+2][CW-1];
        big4[k] <= (magx[k] >> TQW) != '0;
        lo4[k]  <= magx[k][TQW-1:0];
      end
      for (int j = 0; j < 8; j++) dok4[j] <= dok3[j];
      den4 <= cr3[0];
      num4 <= cr3[1];
      u1x4 <= u1x3;
      u1z4 <= u1z3;
      dux4 <= dux3;
      duz4 <= duz3;
    end
  end

  // stage 5: exact product of the two side crosses; a huge factor is above at once
  always_ff @(posedge clk) begin
    if (en) begin
      sp5[0]  <= lo4[2] * lo4[3];
      sp5[1]  <= lo4[0] * lo4[1];
      pre5[0] <= !zrs4[2] && !zrs4[3] && (sgs4[2] == sgs4[3]);
      pre5[1] <= !zrs4[0] && !zrs4[1] && (sgs4[0] == sgs4[1]);
      bg5[0]  <= big4[2] || big4[3];
      bg5[1]  <= big4[0] || big4[1];
      nzden5  <= nzden4;
      zden5   <= zden4;
      for (int k = 0; k < 4; k++) nzs5[k] <= nzs4[k];
      for (int j = 0; j < 8; j++) dok5[j] <= dok4[j];
      den5 <= den4;
      num5 <= num4;
      u1x5 <= u1x4;
      u1z5 <= u1z4;
      dux5 <= dux4;
      duz5 <= duz4;
    end
  end

  // stage 6
  always_comb begin
    tq = (2*TQW)'(tolerance) << (2 * F);
    for (int j = 0; j < 2; j++) above[j] = pre5[j] && (bg5[j] || (sp5[j] > tq));
    near   = nzs5[0] && nzs5[1];
    on_any = (nzs5[2] && dok5[0] && dok5[1]) || (nzs5[3] && dok5[2] && dok5[3]) ||
             (nzs5[0] && dok5[4] && dok5[5]) || (nzs5[1] && dok5[6] && dok5[7]);
    meet   = near ? on_any : (!above[0] && !above[1]);
    hit    = !zden5 && !nzden5 && meet;
  end

  always_ff @(posedge clk) begin
    if (en) out_item <= {den5, num5, duz5, dux5, u1z5, u1x5, hit};
  end

endmodule

[rtl/sid_queue.sv]
// ----------------------------------------------------------------------------
// sid_queue
// Small register queue between the classify and divide pipelines.
// ----------------------------------------------------------------------------
module sid_queue import sid_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = SID_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_item
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wptr, rptr;
  logic [CNTW-1:0]  count;
  logic             push, pop;

  assign in_ready  = count != CNTW'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH)) else $error("queue count beyond depth");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("push lost");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1) else $error("pop lost");

endmodule

[rtl/sid_back.sv]
// ----------------------------------------------------------------------------
// sid_back
// Back pipeline: offset products, pipelined restoring divide, saturation.
// ----------------------------------------------------------------------------
module sid_back import sid_pkg::*; #(
  parameter int W = SID_COORD_WIDTH,
  parameter int IW = 1 + 2*W + 2*(W+1) + 2*(2*(W+1)+1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IW-1:0]       in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_z
);

  localparam int DW    = W + 1;
  localparam int CW    = 2 * DW + 1;
  localparam int PPW   = DW + CW;
  localparam int RW    = PPW + 1;
  // quotient bits kept; any larger quotient saturates the sum anyway
  localparam int QB    = W + 2;
  localparam int SW    = QB + 2;
  localparam int O_U1Z = 1 + W;
  localparam int O_DUX = 1 + 2*W;
  localparam int O_DUZ = O_DUX + DW;
  localparam int O_NUM = O_DUZ + DW;
  localparam int O_DEN = O_NUM + CW;

  localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - 1;
  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic vb1, vb2, vb3;

  logic                 hit1, hit2, hit3;
  logic signed [W-1:0]  u1x1, u1z1, u1x2, u1z2, u1x3, u1z3;
  logic signed [DW-1:0] dux1, duz1;
  logic signed [CW-1:0] num1, den1, den2;
  logic signed [PPW-1:0] px2, pz2;
  logic [PPW-1:0]       mx3, mz3;
  logic [CW-1:0]        dm3;
  logic                 sx3, sz3;

  logic                 vd  [QB+1];
  logic                 hd  [QB+1];
  logic signed [W-1:0]  ux  [QB+1];
  logic signed [W-1:0]  uz  [QB+1];
  logic                 ovx [QB+1];
  logic                 ovz [QB+1];
  logic                 sgx [QB+1];
  logic                 sgz [QB+1];
  logic [RW-1:0]        rx  [QB+1];
  logic [RW-1:0]        rz  [QB+1];
  logic [QB-1:0]        qx  [QB+1];
  logic [QB-1:0]        qz  [QB+1];
  logic [CW-1:0]        dm  [QB+1];
  logic [RW-1:0]        tsh [QB];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  function automatic logic [W-1:0] sat_add(logic signed [W-1:0] u1, logic [QB-1:0] q,
                                           logic neg, logic ovf);
    logic signed [QB:0]   qs;
    logic signed [SW-1:0] sum;
    qs  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = SW'(u1) + SW'(qs);
    if (ovf)               return neg ? MIN_W : MAX_W;
    else if (sum > SAT_HI) return MAX_W;
    else if (sum < SAT_LO) return MIN_W;
    else                   return sum[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
      vb3 <= 1'b0;
      for (int i = 0; i <= QB; i++) vd[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vb1   <= in_valid;
      vb2   <= vb1;
      vb3   <= vb2;
      vd[0] <= vb3;
      for (int i = 0; i < QB; i++) vd[i+1] <= vd[i];
      out_valid <= vd[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit1 <= in_item[0];
      u1x1 <= in_item[1 +: W];
      u1z1 <= in_item[O_U1Z +: W];
      dux1 <= in_item[O_DUX +: DW];
      duz1 <= in_item[O_DUZ +: DW];
      num1 <= in_item[O_NUM +: CW];
      den1 <= in_item[O_DEN +: CW];

      px2  <= dux1 * num1;
      pz2  <= duz1 * num1;
      den2 <= den1;
      hit2 <= hit1;
      u1x2 <= u1x1;
      u1z2 <= u1z1;

      mx3  <= px2[PPW-1] ? (~px2 + 1'b1) : px2;
      mz3  <= pz2[PPW-1] ? (~pz2 + 1'b1) : pz2;
      dm3  <= den2[CW-1] ? (~den2 + 1'b1) : den2;
      sx3  <= px2[PPW-1] ^ den2[CW-1];
      sz3  <= pz2[PPW-1] ^ den2[CW-1];
      hit3 <= hit2;
      u1x3 <= u1x2;
      u1z3 <= u1z2;
    end
  end

  always_comb begin
    for (int i = 0; i < QB; i++) tsh[i] = RW'(dm[i]) << (QB - 1 - i);
  end

  // one quotient bit per stage, most significant first
  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]  <= RW'(mx3);
      rz[0]  <= RW'(mz3);
      ovx[0] <= (mx3 >> QB) >= PPW'(dm3);
      ovz[0] <= (mz3 >> QB) >= PPW'(dm3);
      qx[0]  <= '0;
      qz[0]  <= '0;
      dm[0]  <= dm3;
      sgx[0] <= sx3;
      sgz[0] <= sz3;
      hd[0]  <= hit3;
      ux[0]  <= u1x3;
      uz[0]  <= u1z3;
      for (int i = 0; i < QB; i++) begin
        if (rx[i] >= tsh[i]) begin
          rx[i+1] <= rx[i] - tsh[i];
          qx[i+1] <= qx[i] | (QB'(1) << (QB - 1 - i));
        end else begin
          rx[i+1] <= rx[i];
          qx[i+1] <= qx[i];
        end
        if (rz[i] >= tsh[i]) begin
          rz[i+1] <= rz[i] - tsh[i];
          qz[i+1] <= qz[i] | (QB'(1) << (QB - 1 - i));
        end else begin
          rz[i+1] <= rz[i];
          qz[i+1] <= qz[i];
        end
        dm[i+1]  <= dm[i];
        ovx[i+1] <= ovx[i];
        ovz[i+1] <= ovz[i];
        sgx[i+1] <= sgx[i];
        sgz[i+1] <= sgz[i];
        hd[i+1]  <= hd[i];
        ux[i+1]  <= ux[i];
        uz[i+1]  <= uz[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit <= hd[QB];
      out_x   <= hd[QB] ? sat_add(ux[QB], qx[QB], sgx[QB], ovx[QB]) : '0;
      out_z   <= hd[QB] ? sat_add(uz[QB], qz[QB], sgz[QB], ovz[QB]) : '0;
    end
  end

endmodule
